>>> rtl/core/mld_pkg.sv
// Shared types and constants for the meter link frame deframer.
// Depends on nothing; imported by every module of the block.
package mld_pkg;

	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE = 8'h16;
	localparam int ADDR_BYTES = 6;
	localparam int MIN_FRAME = 12;
	localparam int ADDR_FRAME = MIN_FRAME + 2 * ADDR_BYTES;
	localparam int ADDR_FLAG_BIT = 5;
	localparam int OUT_BITS = 178;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_CSUM = 2'd1,
		ST_BAD  = 2'd2
	} frame_status_t;

	typedef enum logic {
		KIND_PAYLOAD   = 1'b0,
		KIND_FRAME_END = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t    item_kind;
		logic [7:0]    payload_byte;
		frame_status_t frame_status;
		logic [7:0]    control_byte;
		logic [7:0]    app_function;
		logic [7:0]    sequence_res;
		logic [31:0]   data_id;
		logic [47:0]   source_address;
		logic [47:0]   dest_address;
		logic [15:0]   payload_length;
	} result_t;

endpackage

>>> rtl/core/mld_input_stage.sv
// Input register of the deframer: one received byte held between the stream
// port and the frame engine. Depends on mld_pkg.
module mld_input_stage
	import mld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

>>> rtl/core/mld_frame_engine.sv
// Frame engine: parse state, header capture, running checksum and the result
// of the byte at hand. Depends on mld_pkg.
module mld_frame_engine
	import mld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [3:0] {
		PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_CTRL, PH_SRC, PH_DST,
		PH_FUNC, PH_SEQ, PH_DI, PH_DATA, PH_CS, PH_END
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  func_q, func_d;
	logic [7:0]  seq_q, seq_d;
	logic [31:0] id_q, id_d;
	logic [47:0] src_q, src_d;
	logic [47:0] dst_q, dst_d;
	logic        mis_q, mis_d;

	logic [15:0] overhead;
	logic [15:0] plen;
	logic [16:0] cnt_inc;
	logic [7:0]  sum_add;

	assign overhead = ctrl_q[ADDR_FLAG_BIT] ? 16'(ADDR_FRAME) : 16'(MIN_FRAME);
	assign plen = (len_q >= overhead) ? (len_q - overhead) : 16'd0;
	assign cnt_inc = {1'b0, cnt_q} + 17'd1;
	assign sum_add = sum_q + rx_byte;

	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		cnt_d = cnt_q;
		sum_d = sum_q;
		ctrl_d = ctrl_q;
		func_d = func_q;
		seq_d = seq_q;
		id_d = id_q;
		src_d = src_q;
		dst_d = dst_q;
		mis_d = mis_q;
		res_valid = 1'b0;
		res = '0;
		res.item_kind = KIND_FRAME_END;
		res.frame_status = ST_BAD;
		res.control_byte = ctrl_q;
		res.app_function = func_q;
		res.sequence_res = seq_q;
		res.data_id = id_q;
		res.source_address = src_q;
		res.dest_address = dst_q;
		res.payload_length = 16'd0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == START_BYTE) begin
					len_d = '0;
					cnt_d = '0;
					sum_d = '0;
					ctrl_d = '0;
					func_d = '0;
					seq_d = '0;
					id_d = '0;
					src_d = '0;
					dst_d = '0;
					mis_d = 1'b0;
					phase_d = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				len_d = {8'd0, rx_byte};
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = {rx_byte, len_q[7:0]};
				if ({rx_byte, len_q[7:0]} < 16'(MIN_FRAME)) begin
					res_valid = 1'b1;
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_CTRL;
				end
			end
			PH_CTRL: begin
				ctrl_d = rx_byte;
				sum_d = rx_byte;
				cnt_d = '0;
				res.control_byte = rx_byte;
				if (rx_byte[ADDR_FLAG_BIT]) begin
					if (len_q < 16'(ADDR_FRAME)) begin
						res_valid = 1'b1;
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_SRC;
					end
				end else begin
					phase_d = PH_FUNC;
				end
			end
			PH_SRC, PH_DST: begin
				sum_d = sum_add;
				for (int i = 0; i < ADDR_BYTES; i++) begin
					if (cnt_q[2:0] == 3'(i)) begin
						if (phase_q == PH_SRC) begin
							src_d[8*i +: 8] = src_q[8*i +: 8] | rx_byte;
						end else begin
							dst_d[8*i +: 8] = dst_q[8*i +: 8] | rx_byte;
						end
					end
				end
				if (cnt_inc >= 17'(ADDR_BYTES)) begin
					cnt_d = '0;
					phase_d = (phase_q == PH_SRC) ? PH_DST : PH_FUNC;
				end else begin
					cnt_d = cnt_inc[15:0];
				end
			end
			PH_FUNC: begin
				sum_d = sum_add;
				func_d = rx_byte;
				phase_d = PH_SEQ;
			end
			PH_SEQ: begin
				sum_d = sum_add;
				seq_d = rx_byte;
				cnt_d = '0;
				phase_d = PH_DI;
			end
			PH_DI: begin
				sum_d = sum_add;
				for (int i = 0; i < 4; i++) begin
					if (cnt_q[1:0] == 2'(i)) begin
						id_d[8*i +: 8] = id_q[8*i +: 8] | rx_byte;
					end
				end
				if (cnt_inc >= 17'd4) begin
					cnt_d = '0;
					phase_d = (plen == 16'd0) ? PH_CS : PH_DATA;
				end else begin
					cnt_d = cnt_inc[15:0];
				end
			end
			PH_DATA: begin
				sum_d = sum_add;
				cnt_d = cnt_inc[15:0];
				if (cnt_inc >= {1'b0, plen}) begin
					phase_d = PH_CS;
				end
				res_valid = 1'b1;
				res = '0;
				res.item_kind = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
			end
			PH_CS: begin
				mis_d = (rx_byte != sum_q);
				phase_d = PH_END;
			end
			PH_END: begin
				res_valid = 1'b1;
				res.payload_length = plen;
				if (rx_byte != END_BYTE) begin
					res.frame_status = ST_BAD;
				end else if (mis_q) begin
					res.frame_status = ST_CSUM;
				end else begin
					res.frame_status = ST_GOOD;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			len_q <= len_d;
			cnt_q <= cnt_d;
			sum_q <= sum_d;
			ctrl_q <= ctrl_d;
			func_q <= func_d;
			seq_q <= seq_d;
			id_q <= id_d;
			src_q <= src_d;
			dst_q <= dst_d;
			mis_q <= mis_d;
		end
	end

endmodule

>>> rtl/core/mld_output_stage.sv
// Result register of the deframer, driving the master stream port.
// Depends on mld_pkg.
module mld_output_stage
	import mld_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    out_valid_q,
	input  logic    m_tready,
	output result_t out_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

endmodule

>>> rtl/core/meter_link_frame_deframer_unit.sv
// Top level of the meter link frame deframer: input register, frame engine
// and result register. Depends on mld_pkg and the three mld_ modules.
//
//  Port group   Dir  Payload
//  s_t*         in   s_tdata[7:0] = rx_byte
//  m_t*         out  m_tuser = item_kind; m_tdata = payload and frame header
//
// One byte is taken per cycle while the result side keeps up; a byte passes
// the input register, then the result register. The frame engine steps once
// per byte through a single state register and an 8-bit checksum adder.
// Reset clears the parse state, so the block hunts for a start byte.
// A stalled result holds one byte in the input register; then s_tready drops.
module meter_link_frame_deframer_unit
	import mld_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // rx_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// payload_byte, frame_status, control_byte, app_function, sequence_res,
	// data_id, source_address, dest_address, payload_length, zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser   // item_kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	result_t    out_q;

	assign advance = valid_s1 && (!m_tvalid || m_tready);

	mld_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mld_frame_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mld_output_stage u_output (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && res_valid),
		.res         (res),
		.out_valid_q (m_tvalid),
		.m_tready    (m_tready),
		.out_q       (out_q)
	);

	assign m_tuser = out_q.item_kind;
	assign m_tdata = {
		(OUT_TDATA_W - OUT_BITS)'(0),
		out_q.payload_length,
		out_q.dest_address,
		out_q.source_address,
		out_q.data_id,
		out_q.sequence_res,
		out_q.app_function,
		out_q.control_byte,
		out_q.frame_status,
		out_q.payload_byte
	};

endmodule
